/* src/sct_pkg.sv */
// shared widths and polynomial coefficients for the sine and cosine pipeline
package sct_pkg;

  // phase word after alignment to the top of 32 bits, Q0.32 turns
  localparam int PHASE_W = 32;
  // offset that rounds the phase half up to the nearest quarter turn
  localparam logic [PHASE_W-1:0] QUARTER_HALF = 32'h2000_0000;

  // signed remainder and x squared, both fit in 31 bits
  localparam int MUL_W  = 31;
  localparam int MMAG_W = MUL_W - 1;
  // horner accumulators, signed Q30, magnitude below 2^37
  localparam int ACC_W  = 38;
  localparam int AMAG_W = ACC_W - 1;
  // exact product of two magnitudes
  localparam int PROD_W = AMAG_W + MMAG_W;
  // every product is scaled down by 2^32 with rounding
  localparam int MUL_SHIFT = 32;

  // result fields
  localparam int RES_W   = 32;
  localparam int OUT_W   = 2 * RES_W;
  localparam int Q30_FRAC = 30;

  // output queue
  localparam int OUTQ_DEPTH = 16;
  localparam int OUTQ_PTR_W = 4;

  // odd polynomial for sine, Q30
  localparam logic signed [ACC_W-1:0] COEF_S7 = ACC_W'(-(64'sd9940169 <<< 13));
  localparam logic signed [ACC_W-1:0] COEF_S5 = ACC_W'(64'sd668505 <<< 17);
  localparam logic signed [ACC_W-1:0] COEF_S3 = ACC_W'(-(64'sd10837494 <<< 12));
  localparam logic signed [ACC_W-1:0] COEF_S1 = ACC_W'(64'sd13176795 <<< 9);
  // even polynomial for cosine, Q30
  localparam logic signed [ACC_W-1:0] COEF_C6 = ACC_W'(-(64'sd10944157 <<< 13));
  localparam logic signed [ACC_W-1:0] COEF_C4 = ACC_W'(64'sd8509030 <<< 13);
  localparam logic signed [ACC_W-1:0] COEF_C2 = ACC_W'(-(64'sd10348991 <<< 11));
  localparam logic signed [ACC_W-1:0] COEF_C0 = ACC_W'((64'sd1 <<< 30) - (64'sd1 <<< 6));

endpackage

/* src/sct_cell.sv */
// one horner cell: rounded product of accumulator and multiplier plus a constant
module sct_cell #(
  parameter logic signed [sct_pkg::ACC_W-1:0] ADD_K = '0
) (
  input  logic                               clk,
  input  logic signed [sct_pkg::ACC_W-1:0]   acc_in,
  input  logic signed [sct_pkg::MUL_W-1:0]   mul_in,
  output logic signed [sct_pkg::ACC_W-1:0]   acc_out,
  output logic signed [sct_pkg::MUL_W-1:0]   mul_out
);

  localparam int RND_W = sct_pkg::PROD_W + 1 - sct_pkg::MUL_SHIFT;
  localparam logic [sct_pkg::PROD_W:0] RND_HALF =
    (sct_pkg::PROD_W + 1)'(1) << (sct_pkg::MUL_SHIFT - 1);

  logic        [sct_pkg::AMAG_W-1:0] acc_mag;
  logic        [sct_pkg::MMAG_W-1:0] mul_mag;
  logic        [sct_pkg::PROD_W-1:0] prod;
  logic                              neg;
  logic signed [sct_pkg::MUL_W-1:0]  mul_mid;
  logic        [sct_pkg::PROD_W:0]   rnd_sum;
  logic        [RND_W-1:0]           rnd;
  logic signed [sct_pkg::ACC_W-1:0]  rnd_ext;
  logic signed [sct_pkg::ACC_W-1:0]  term;

  // sign and magnitude, as the rounding is symmetric about zero
  always_comb begin
    acc_mag = acc_in[sct_pkg::ACC_W-1] ? sct_pkg::AMAG_W'(-acc_in)
                                       : sct_pkg::AMAG_W'(acc_in);
    mul_mag = mul_in[sct_pkg::MUL_W-1] ? sct_pkg::MMAG_W'(-mul_in)
                                       : sct_pkg::MMAG_W'(mul_in);
  end

  always_ff @(posedge clk) begin
    prod    <= acc_mag * mul_mag;
    neg     <= acc_in[sct_pkg::ACC_W-1] ^ mul_in[sct_pkg::MUL_W-1];
    mul_mid <= mul_in;
  end

  always_comb begin
    rnd_sum = {1'b0, prod} + RND_HALF;
    rnd     = rnd_sum[sct_pkg::PROD_W:sct_pkg::MUL_SHIFT];
    rnd_ext = signed'(sct_pkg::ACC_W'(rnd));
    term    = neg ? -rnd_ext : rnd_ext;
  end

  always_ff @(posedge clk) begin
    acc_out <= term + ADD_K;
    mul_out <= mul_mid;
  end

endmodule

/* src/sct_finish.sv */
// quadrant fold, final rounding and saturation for both outputs
module sct_finish #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic                               clk,
  input  logic signed [sct_pkg::ACC_W-1:0]   sin_raw,
  input  logic signed [sct_pkg::ACC_W-1:0]   cos_raw,
  input  logic        [1:0]                  quad,
  output logic signed [sct_pkg::RES_W-1:0]   sine,
  output logic signed [sct_pkg::RES_W-1:0]   cosine
);

  localparam int SH = sct_pkg::Q30_FRAC - RESULT_FRAC_BITS;
  localparam logic [sct_pkg::ACC_W-1:0] HALF =
    sct_pkg::ACC_W'((64'd1 << SH) >> 1);
  localparam logic [sct_pkg::ACC_W-1:0] LIM =
    sct_pkg::ACC_W'(64'd1 << RESULT_FRAC_BITS);

  logic signed [sct_pkg::ACC_W-1:0] sel_s;
  logic signed [sct_pkg::ACC_W-1:0] sel_c;
  logic                             flip_s;
  logic                             flip_c;
  logic        [sct_pkg::ACC_W-1:0] mag_s;
  logic        [sct_pkg::ACC_W-1:0] mag_c;
  logic        [sct_pkg::ACC_W-1:0] rnd_s;
  logic        [sct_pkg::ACC_W-1:0] rnd_c;
  logic        [sct_pkg::RES_W-1:0] sat_s;
  logic        [sct_pkg::RES_W-1:0] sat_c;
  logic                             neg_s;
  logic                             neg_c;

  always_comb begin
    // odd quadrant swaps the lanes, each keeps the flip of its source
    if (quad[0]) begin
      sel_s  = cos_raw;
      sel_c  = sin_raw;
      flip_s = quad[1];
      flip_c = quad[0] ^ quad[1];
    end else begin
      sel_s  = sin_raw;
      sel_c  = cos_raw;
      flip_s = quad[0] ^ quad[1];
      flip_c = quad[1];
    end
    neg_s = sel_s[sct_pkg::ACC_W-1] ^ flip_s;
    neg_c = sel_c[sct_pkg::ACC_W-1] ^ flip_c;
    mag_s = sel_s[sct_pkg::ACC_W-1] ? unsigned'(-sel_s) : unsigned'(sel_s);
    mag_c = sel_c[sct_pkg::ACC_W-1] ? unsigned'(-sel_c) : unsigned'(sel_c);
    rnd_s = (mag_s + HALF) >> SH;
    rnd_c = (mag_c + HALF) >> SH;
    sat_s = (rnd_s > LIM) ? sct_pkg::RES_W'(LIM) : sct_pkg::RES_W'(rnd_s);
    sat_c = (rnd_c > LIM) ? sct_pkg::RES_W'(LIM) : sct_pkg::RES_W'(rnd_c);
  end

  always_ff @(posedge clk) begin
    sine   <= neg_s ? -signed'(sat_s) : signed'(sat_s);
    cosine <= neg_c ? -signed'(sat_c) : signed'(sat_c);
  end

endmodule

/* src/sct_outq.sv */
// output queue that holds finished results until the sink takes them
module sct_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [sct_pkg::OUT_W-1:0]     wr_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sct_pkg::OUT_W-1:0]     m_tdata
);

  logic [sct_pkg::OUT_W-1:0]      mem [sct_pkg::OUTQ_DEPTH];
  logic [sct_pkg::OUTQ_PTR_W:0]   wr_ptr;
  logic [sct_pkg::OUTQ_PTR_W:0]   rd_ptr;
  logic [sct_pkg::OUT_W-1:0]      head;
  logic                           head_vld;
  logic                           mem_empty;
  logic                           head_free;
  logic                           mem_wr;
  logic                           mem_rd;

  // the head register drives the output, the memory holds the rest in order
  assign mem_empty = (wr_ptr == rd_ptr);
  assign head_free = !head_vld || m_tready;
  assign mem_rd    = head_free && !mem_empty;
  // a result bypasses the memory when the head is free and nothing waits
  assign mem_wr    = wr_en && !(head_free && mem_empty);
  assign m_tvalid  = head_vld;
  assign m_tdata   = head;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_ptr[sct_pkg::OUTQ_PTR_W-1:0]] <= wr_data;
    end
    if (mem_rd) begin
      head <= mem[rd_ptr[sct_pkg::OUTQ_PTR_W-1:0]];
    end else if (head_free && wr_en) begin
      head <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      head_vld <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (mem_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (head_free) begin
        head_vld <= mem_rd || wr_en;
      end
    end
  end

endmodule

/* src/sine_cosine_of_turns.sv */
// sine and cosine of a phase in turns: quadrant fold, horner cell chain, output queue
// throughput: one transaction per cycle through the two-stage horner cells of the chain,
// held off when the credit count reaches 16 accepted but undelivered transactions
// a 16-entry output queue and a credit count keep full rate while the sink stalls briefly
// reset: synchronous, clears the valid line, the credit count and the queue pointers
// no clearing pass; s_tready is high from the first cycle after reset
module sine_cosine_of_turns #(
  parameter int PHASE_BITS       = 32,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((PHASE_BITS + 7) / 8) * 8-1:0] s_tdata,   // phase
  // output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sct_pkg::OUT_W-1:0]            m_tdata    // sine, cosine
);

  // cycles from the input register to the finished result register
  localparam int PIPE_LAT = 11;
  // cell outputs appear at even offsets; x is needed again by the last sine cell
  localparam int X_DLY    = 6;
  localparam int Q_DLY    = 10;
  localparam int PEND_W   = $clog2(sct_pkg::OUTQ_DEPTH + 1);

  // input side
  logic                              in_acc;
  logic [sct_pkg::PHASE_W-1:0]       phase_al;
  logic [sct_pkg::PHASE_W-1:0]       phase_rnd;
  logic [1:0]                        quad_in;
  logic [sct_pkg::PHASE_W-1:0]       rem_in;

  // stage registers and side delay lines
  logic signed [sct_pkg::MUL_W-1:0]  x0;
  logic        [1:0]                 q_pipe [Q_DLY+1];
  logic signed [sct_pkg::MUL_W-1:0]  x_pipe [X_DLY];
  logic        [PIPE_LAT:0]          vld;

  // cell chain links
  logic signed [sct_pkg::ACC_W-1:0]  sq_acc;
  logic signed [sct_pkg::MUL_W-1:0]  sq_x;
  logic signed [sct_pkg::MUL_W-1:0]  x2;
  logic signed [sct_pkg::ACC_W-1:0]  s1, s2, s3, s4;
  logic signed [sct_pkg::MUL_W-1:0]  m1, m2, m3, m4;
  logic signed [sct_pkg::ACC_W-1:0]  c1, c2, c3;
  logic signed [sct_pkg::MUL_W-1:0]  cm1, cm2, cm3;
  logic signed [sct_pkg::ACC_W-1:0]  c_d1, c_d2;

  // results
  logic signed [sct_pkg::RES_W-1:0]  sine;
  logic signed [sct_pkg::RES_W-1:0]  cosine;

  // credit: items accepted but not yet delivered
  logic [PEND_W-1:0]                 pend;
  logic [PEND_W-1:0]                 pend_next;
  logic                              out_acc;

  assign s_tready = !rst && (pend != PEND_W'(sct_pkg::OUTQ_DEPTH));
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  // align the phase to Q0.32, round half up to a quarter turn, keep the remainder
  always_comb begin
    phase_al  = sct_pkg::PHASE_W'(s_tdata[PHASE_BITS-1:0]) << (sct_pkg::PHASE_W - PHASE_BITS);
    phase_rnd = phase_al + sct_pkg::QUARTER_HALF;
    quad_in   = phase_rnd[sct_pkg::PHASE_W-1:sct_pkg::PHASE_W-2];
    rem_in    = phase_al - {quad_in, {(sct_pkg::PHASE_W - 2){1'b0}}};
  end

  // payload registers run freely, the valid line tags live slots
  always_ff @(posedge clk) begin
    x0        <= signed'(rem_in[sct_pkg::MUL_W-1:0]);
    q_pipe[0] <= quad_in;
    for (int i = 1; i <= Q_DLY; i++) begin
      q_pipe[i] <= q_pipe[i-1];
    end
    x_pipe[0] <= sq_x;
    for (int i = 1; i < X_DLY; i++) begin
      x_pipe[i] <= x_pipe[i-1];
    end
    c_d1 <= c3;
    c_d2 <= c_d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-1:0], in_acc};
    end
  end

  // x squared, Q32, from the same cell as the horner steps
  sct_cell #(.ADD_K('0)) u_sq (
    .clk     (clk),
    .acc_in  (sct_pkg::ACC_W'(x0)),
    .mul_in  (x0),
    .acc_out (sq_acc),
    .mul_out (sq_x)
  );

  // x squared is at most 2^26, so the low bits carry it
  assign x2 = signed'(sq_acc[sct_pkg::MUL_W-1:0]);

  // odd polynomial lane, x squared passes from cell to cell
  sct_cell #(.ADD_K(sct_pkg::COEF_S5)) u_s1 (
    .clk (clk), .acc_in (sct_pkg::COEF_S7), .mul_in (x2), .acc_out (s1), .mul_out (m1)
  );
  sct_cell #(.ADD_K(sct_pkg::COEF_S3)) u_s2 (
    .clk (clk), .acc_in (s1), .mul_in (m1), .acc_out (s2), .mul_out (m2)
  );
  sct_cell #(.ADD_K(sct_pkg::COEF_S1)) u_s3 (
    .clk (clk), .acc_in (s2), .mul_in (m2), .acc_out (s3), .mul_out (m3)
  );
  // last odd step multiplies by x itself
  sct_cell #(.ADD_K('0)) u_s4 (
    .clk (clk), .acc_in (s3), .mul_in (x_pipe[X_DLY-1]), .acc_out (s4), .mul_out (m4)
  );

  // even polynomial lane
  sct_cell #(.ADD_K(sct_pkg::COEF_C4)) u_c1 (
    .clk (clk), .acc_in (sct_pkg::COEF_C6), .mul_in (x2), .acc_out (c1), .mul_out (cm1)
  );
  sct_cell #(.ADD_K(sct_pkg::COEF_C2)) u_c2 (
    .clk (clk), .acc_in (c1), .mul_in (cm1), .acc_out (c2), .mul_out (cm2)
  );
  sct_cell #(.ADD_K(sct_pkg::COEF_C0)) u_c3 (
    .clk (clk), .acc_in (c2), .mul_in (cm2), .acc_out (c3), .mul_out (cm3)
  );

  // quadrant fold, rounding to the result format, saturation
  sct_finish #(.RESULT_FRAC_BITS(RESULT_FRAC_BITS)) u_fin (
    .clk     (clk),
    .sin_raw (s4),
    .cos_raw (c_d2),
    .quad    (q_pipe[Q_DLY]),
    .sine    (sine),
    .cosine  (cosine)
  );

  // finished results wait here; credit guarantees a free entry
  sct_outq u_q (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (vld[PIPE_LAT]),
    .wr_data  ({cosine, sine}),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always_comb begin
    pend_next = pend;
    if (in_acc && !out_acc) begin
      pend_next = pend + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_next = pend - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

endmodule

/* src/sct_checker.sv */
// port-level checks for the sine and cosine block, bound to the top level
module sct_checker #(
  parameter int PHASE_BITS       = 32,
  parameter int RESULT_FRAC_BITS = 30
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [((PHASE_BITS + 7) / 8) * 8-1:0] s_tdata,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [sct_pkg::OUT_W-1:0]             m_tdata
);

  localparam logic signed [sct_pkg::RES_W-1:0] LIM =
    sct_pkg::RES_W'(64'sd1 <<< RESULT_FRAC_BITS);

  logic signed [sct_pkg::RES_W-1:0] chk_sine;
  logic signed [sct_pkg::RES_W-1:0] chk_cosine;
  logic [7:0]                       open_cnt;

  assign chk_sine   = signed'(m_tdata[sct_pkg::RES_W-1:0]);
  assign chk_cosine = signed'(m_tdata[sct_pkg::OUT_W-1:sct_pkg::RES_W]);

  // transactions accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= '0;
    end else begin
      open_cnt <= open_cnt + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chk_sine <= LIM) && (chk_sine >= -LIM) &&
                 (chk_cosine <= LIM) && (chk_cosine >= -LIM))
    else $error("result outside plus or minus one");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (open_cnt != 8'd0))
    else $error("result offered with no transaction outstanding");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (open_cnt == 8'd0) |-> s_tready)
    else $error("empty block refuses input");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind sine_cosine_of_turns sct_checker #(
  .PHASE_BITS       (PHASE_BITS),
  .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
) u_sct_checker (.*);

/* verif/tb.sv */
// testbench for sine_cosine_of_turns: directed phase table, random phases, bit-exact prediction
`timescale 1ns / 1ps

module tb;

  localparam int PH_BITS  = 32;
  localparam int RES_FRAC = 30;
  localparam int RANDOM_PHASES = 1600;
  // settle time after the drain, so that any stray result can show
  localparam int DRAIN_CYCLES = 40;
  // limit on the whole run, well above the slowest legal run
  localparam longint RUN_LIMIT_NS = 2_000_000;

  // polynomial coefficients, signed Q30
  localparam longint SIN_K7 = -(longint'(9940169) <<< 13);
  localparam longint SIN_K5 = longint'(668505) <<< 17;
  localparam longint SIN_K3 = -(longint'(10837494) <<< 12);
  localparam longint SIN_K1 = longint'(13176795) <<< 9;
  localparam longint COS_K6 = -(longint'(10944157) <<< 13);
  localparam longint COS_K4 = longint'(8509030) <<< 13;
  localparam longint COS_K2 = -(longint'(10348991) <<< 11);
  localparam longint COS_K0 = (longint'(1) <<< 30) - (longint'(1) <<< 6);

  // value of the even polynomial at zero remainder, the largest output the block makes on axis
  localparam logic signed [31:0] AXIS_PEAK = 32'sd1073741760;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } sincos_t;

  typedef struct packed {
    logic [31:0]        phase;
    bit                 typed;   // expected value below is read off directly
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } phase_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;           // phase
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [sct_pkg::OUT_W-1:0] m_tdata;  // sine, cosine

  sincos_t pending_sincos[$];          // expected results, oldest first
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned phases_sent = 0;
  int unsigned eighth_ties = 0;
  int unsigned quadrant_hits [4] = '{0, 0, 0, 0};

  // sender burst state
  int unsigned burst_left = 0;

  // receiver pattern state
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;

  sine_cosine_of_turns #(
    .PHASE_BITS       (PH_BITS),
    .RESULT_FRAC_BITS (RES_FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // directed rows: the four axis points carry their values, the rest go through the predictor
  phase_row_t axis_and_edges [0:21] = '{
    '{32'h0000_0000, 1'b1, 32'sd0, AXIS_PEAK},
    '{32'h4000_0000, 1'b1, AXIS_PEAK, 32'sd0},
    '{32'h8000_0000, 1'b1, 32'sd0, -AXIS_PEAK},
    '{32'hC000_0000, 1'b1, -AXIS_PEAK, 32'sd0},
    '{32'h2000_0000, 1'b0, 32'sd0, 32'sd0},   // eighth-turn tie, rounds up into quadrant 1
    '{32'h1FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'h6000_0000, 1'b0, 32'sd0, 32'sd0},
    '{32'h5FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'hA000_0000, 1'b0, 32'sd0, 32'sd0},
    '{32'h9FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'hE000_0000, 1'b0, 32'sd0, 32'sd0},   // tie that wraps back to quadrant 0
    '{32'hDFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'hFFFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'h0000_0001, 1'b0, 32'sd0, 32'sd0},
    '{32'h7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'h8000_0001, 1'b0, 32'sd0, 32'sd0},
    '{32'h3FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
    '{32'h4000_0001, 1'b0, 32'sd0, 32'sd0},
    '{32'h5555_5555, 1'b0, 32'sd0, 32'sd0},
    '{32'hAAAA_AAAA, 1'b0, 32'sd0, 32'sd0},
    '{32'h1000_0000, 1'b0, 32'sd0, 32'sd0},
    '{32'hF000_0000, 1'b0, 32'sd0, 32'sd0}
  };

  // (a*b) / 2^32, rounded to nearest with ties away from zero
  function automatic longint scaled_product(longint a, longint b);
    longint unsigned ma, mb, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << 31)) >> 32;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // q30 to the output format, then clamp to plus or minus one
  function automatic logic signed [31:0] q30_to_result(longint v);
    longint unsigned mag;
    longint lim;
    int sh;
    sh  = 30 - RES_FRAC;
    lim = longint'(1) <<< RES_FRAC;
    if (sh > 0) begin
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      v = (v < 0) ? -longint'(mag) : longint'(mag);
    end
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[31:0];
  endfunction

  function automatic sincos_t sincos_of_phase(logic [31:0] phase);
    logic [31:0] turn, rounded, rem;
    logic [1:0]  quad;
    longint      x, xx, s, c, t;
    sincos_t     r;
    turn    = phase << (32 - PH_BITS);
    rounded = turn + 32'h2000_0000;
    quad    = rounded[31:30];
    rem     = turn - {quad, 30'd0};
    x       = longint'($signed(rem));
    xx      = scaled_product(x, x);
    // horner steps, odd polynomial then even
    s = scaled_product(SIN_K7, xx) + SIN_K5;
    s = scaled_product(s, xx) + SIN_K3;
    s = scaled_product(s, xx) + SIN_K1;
    s = scaled_product(s, x);
    c = scaled_product(COS_K6, xx) + COS_K4;
    c = scaled_product(c, xx) + COS_K2;
    c = scaled_product(c, xx) + COS_K0;
    // quadrant fold
    if (quad[0] ^ quad[1]) s = -s;
    if (quad[1]) c = -c;
    if (quad[0]) begin
      t = s;
      s = c;
      c = t;
    end
    r.phase  = phase;
    r.sine   = q30_to_result(s);
    r.cosine = q30_to_result(c);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // random phases lean on the quadrant boundaries where the fold and rounding act
  function automatic logic [31:0] pick_phase();
    logic [31:0] base;
    int          off;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6: begin
        base = {3'($urandom_range(0, 7)), 29'd0};
        off  = $urandom_range(0, 512) - 256;
        return base + 32'(off);
      end
      7: begin
        // tiny angles either side of zero
        off = $urandom_range(0, 65536) - 32768;
        return 32'(off);
      end
      default: return {4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 20'd0};
    endcase
  endfunction

  // present one phase, hold it until the block takes it, then book the expected result
  task automatic send_phase(input sincos_t want);
    if (burst_left == 0) begin
      int unsigned gap;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= want.phase;
    do @(posedge clk); while (!s_tready);
    pending_sincos.push_back(want);
    phases_sent++;
    if (want.phase[29:0] == 30'h2000_0000) eighth_ties++;
    quadrant_hits[2'(({2'b0, want.phase[31:30]} + {3'b0, want.phase[29]}))]++;
  endtask

  // receiver: switches between open, light stall, heavy stall and a fixed periodic pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
        sink_left <= $urandom_range(20, 200);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:     m_tready <= 1'b1;
        SINK_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
        SINK_PERIODIC: m_tready <= (sink_left[3:0] < 4'd4);
        default:       m_tready <= 1'b1;
      endcase
    end
  end

  // result checker, one transaction per edge at most
  always @(posedge clk) begin
    sincos_t            want;
    logic signed [31:0] got_sine, got_cosine;
    if (!rst && m_tvalid && m_tready) begin
      got_sine   = m_tdata[31:0];
      got_cosine = m_tdata[63:32];
      if (pending_sincos.size() == 0) begin
        note_mismatch($sformatf("unexpected result transaction: sine %0d cosine %0d",
                                got_sine, got_cosine));
      end else begin
        want = pending_sincos.pop_front();
        results_checked++;
        if (got_sine !== want.sine)
          note_mismatch($sformatf("phase %h sine got %0d want %0d",
                                  want.phase, got_sine, want.sine));
        if (got_cosine !== want.cosine)
          note_mismatch($sformatf("phase %h cosine got %0d want %0d",
                                  want.phase, got_cosine, want.cosine));
      end
    end
  end

  initial begin
    sincos_t want;
    int unsigned settle;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (axis_and_edges[i]) begin
      if (axis_and_edges[i].typed) begin
        want.phase  = axis_and_edges[i].phase;
        want.sine   = axis_and_edges[i].sine;
        want.cosine = axis_and_edges[i].cosine;
      end else begin
        want = sincos_of_phase(axis_and_edges[i].phase);
      end
      send_phase(want);
    end

    // random phases
    repeat (RANDOM_PHASES) send_phase(sincos_of_phase(pick_phase()));
    s_tvalid <= 1'b0;

    // drain, then give the pipeline time to show any stray result
    while (pending_sincos.size() != 0) @(posedge clk);
    settle = DRAIN_CYCLES;
    repeat (settle) @(posedge clk);

    $display("covered %0d phase transactions (%0d directed), %0d results compared",
             phases_sent, $size(axis_and_edges), results_checked);
    $display("quadrants 0..3 hit %0d/%0d/%0d/%0d times, %0d exact eighth-turn ties",
             quadrant_hits[0], quadrant_hits[1], quadrant_hits[2], quadrant_hits[3],
             eighth_ties);
    if (mismatches == 0) begin
      $display("sine_cosine_of_turns test passed");
    end else begin
      $display("sine_cosine_of_turns test failed");
    end
    $finish;
  end

  // hard stop if the handshakes never complete
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results still expected", pending_sincos.size());
    $display("sine_cosine_of_turns test failed");
    $finish;
  end

endmodule
